### hdl/rre_pkg.sv
// Shared types, constants and byte tables of the raw ringtone encoder.
package rre_pkg;

  // Input operation codes.
  localparam logic [1:0] OpStart  = 2'd0;
  localparam logic [1:0] OpNote   = 2'd1;
  localparam logic [1:0] OpFinish = 2'd2;

  // Configuration register indexes.
  localparam logic CfgCapacity = 1'b0;
  localparam logic CfgFormat   = 1'b1;

  localparam logic [15:0] CapacityReset = 16'hffff;
  localparam logic [15:0] VibraLimit    = 16'd300;
  localparam logic [12:0] MaxDuration   = 13'd7650;
  localparam logic [7:0]  PauseCode     = 8'h40;
  localparam logic [7:0]  PauseNote     = 8'hff;
  localparam logic [7:0]  GapLength     = 8'h01;
  localparam logic [7:0]  VibraMark     = 8'h0a;
  localparam logic [7:0]  VibraOnByte   = 8'hfe;
  localparam logic [7:0]  VibraOffByte  = 8'h01;
  localparam logic [7:0]  LengthMax     = 8'hff;
  localparam logic [7:0]  BaseNewer     = 8'd90;
  localparam logic [7:0]  BaseOlder     = 8'd114;
  localparam logic [7:0]  StepsPerOct   = 8'd14;
  localparam logic [7:0]  SemisPerOct   = 8'd12;
  localparam logic [3:0]  HdrLast       = 4'd4;
  localparam logic [3:0]  TrlLast       = 4'd11;
  localparam logic [15:0] HdrBytes      = 16'd5;
  localparam logic [15:0] TrlBytes      = 16'd12;
  localparam logic [15:0] PairBytes     = 16'd2;

  typedef enum logic {
    AluAdd = 1'b0,
    AluSub = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [15:0] a;
    logic [15:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] res;
    logic        borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        status;
    logic [15:0] total;
    logic        last;
  } out_item_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h02;
      4'd2:    b = 8'hfc;
      4'd3:    b = 8'h0a;
      4'd4:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trl_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0, 4'd1, 4'd2: b = 8'h0a;
      4'd3:             b = 8'hfe;
      4'd4:             b = 8'h40;
      4'd5:             b = 8'h20;
      4'd6:             b = 8'h07;
      4'd7:             b = 8'h0b;
      default:          b = 8'hff;
    endcase
    return b;
  endfunction

  // Semitone offset of each step within an octave.
  function automatic logic [7:0] step_offset(input logic [3:0] step);
    logic [7:0] s;
    unique case (step)
      4'd0:    s = 8'd0;
      4'd1:    s = 8'd1;
      4'd2:    s = 8'd2;
      4'd3:    s = 8'd3;
      4'd4:    s = 8'd4;
      4'd5:    s = 8'd4;
      4'd6:    s = 8'd5;
      4'd7:    s = 8'd6;
      4'd8:    s = 8'd7;
      4'd9:    s = 8'd8;
      4'd10:   s = 8'd9;
      4'd11:   s = 8'd10;
      4'd12:   s = 8'd11;
      4'd13:   s = 8'd11;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

### hdl/rre_alu.sv
// Shared 16-bit add/subtract unit used by the encoder sequencer.
module rre_alu (
  input  rre_pkg::alu_req_t req_i,
  output rre_pkg::alu_rsp_t rsp_o
);

  logic [16:0] sum;

  always_comb begin
    unique case (req_i.op)
      rre_pkg::AluAdd: sum = {1'b0, req_i.a} + {1'b0, req_i.b};
      rre_pkg::AluSub: sum = {1'b0, req_i.a} - {1'b0, req_i.b};
      default:         sum = '0;
    endcase
  end

  // For a subtraction the top bit is the borrow, i.e. a < b.
  assign rsp_o.res    = sum[15:0];
  assign rsp_o.borrow = sum[16];

endmodule

### hdl/rre_out_stage.sv
// Output register that decouples the sequencer from a stalling consumer.
module rre_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rre_pkg::out_item_t item_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         data_byte_o,
  output logic               status_o,
  output logic [15:0]        total_length_o,
  output logic               last_of_run_o
);

  logic               valid_q;
  rre_pkg::out_item_t item_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign data_byte_o    = item_q.data;
  assign status_o       = item_q.status;
  assign total_length_o = item_q.total;
  assign last_of_run_o  = item_q.last;

endmodule

### hdl/ringtone_raw_encoder_core.sv
// Top level of the raw ringtone encoder: configuration, sequencer and state.
//
// The encoder takes one item at a time and holds in_stall_o high until the
// last byte of that item has been handed to the output register. Almost all
// arithmetic (budget checks, byte count, vibration timing, note code and
// length splitting) runs through a single 16-bit add/subtract unit, one
// operation per cycle, so the sequencer walks through a short chain of steps
// for each item; only the octave accumulator and the byte index have their
// own adders. Bytes leave through an output register at up to one per cycle
// while the consumer does not stall. A start item checks the budget and
// emits the header; a finish item checks the budget, works out the total and
// emits the trailer. A sounding note finds its octave number (at most 18, by
// repeated subtraction of fourteen), then emits, each after its own budget
// check, a due vibration toggle, its code and length pairs and a trailing
// gap, up to 64 bytes. A pause skips the octave search and the trailing gap.
// Once the byte budget runs out, one result with status 1 and a zero data
// byte ends the item, and every later note or finish item returns that single
// result until the next start item. Opcode 3 is dropped without any transfer.
// Configuration writes are expected only while the block is idle.
module ringtone_raw_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  note_code_i,
  input  logic [12:0] duration_units_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic        status_o,
  output logic [15:0] total_length_o,
  output logic        last_of_run_o
);

  // One-hot sequencer states.
  typedef enum logic [21:0] {
    StIdle    = 22'b1 << 0,
    StHdrChk  = 22'b1 << 1,
    StHdrEmit = 22'b1 << 2,
    StTrlChk  = 22'b1 << 3,
    StTrlTot  = 22'b1 << 4,
    StTrlEmit = 22'b1 << 5,
    StFail    = 22'b1 << 6,
    StVibChk  = 22'b1 << 7,
    StVibAdd  = 22'b1 << 8,
    StPause   = 22'b1 << 9,
    StDiv     = 22'b1 << 10,
    StCode    = 22'b1 << 11,
    StVibBud  = 22'b1 << 12,
    StVibE0   = 22'b1 << 13,
    StVibE1   = 22'b1 << 14,
    StPairChk = 22'b1 << 15,
    StPairBud = 22'b1 << 16,
    StPairE0  = 22'b1 << 17,
    StPairE1  = 22'b1 << 18,
    StGapBud  = 22'b1 << 19,
    StGapE0   = 22'b1 << 20,
    StGapE1   = 22'b1 << 21
  } state_e;

  state_e state_q, state_d;

  // Configuration and architectural state.
  logic [15:0] cap_q;
  logic        newer_q;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [15:0] vibra_time_q, vibra_time_d;
  logic        vibra_on_q, vibra_on_d;
  logic        ovf_q, ovf_d;

  // Per-item working registers.
  logic [7:0]  note_q, note_d;
  logic [12:0] p_q, p_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  acc_q, acc_d;
  logic        tog_q, tog_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] tot_q, tot_d;

  rre_pkg::alu_req_t  alu_req;
  rre_pkg::alu_rsp_t  alu_rsp;
  rre_pkg::out_item_t out_item;
  logic               out_push;
  logic               out_ready;
  logic               in_take;
  logic [12:0]        dur_sat;
  logic               p_done;
  logic               note_end;

  rre_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  rre_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (out_push),
    .item_i         (out_item),
    .ready_o        (out_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .status_o       (status_o),
    .total_length_o (total_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_take    = in_valid_i && !in_stall_o;
  assign dur_sat    = (duration_units_i > rre_pkg::MaxDuration) ? rre_pkg::MaxDuration
                                                                : duration_units_i;

  // No further pair is due once the remaining duration is at most one, and a
  // pause code carries no trailing gap, so then the current byte ends the item.
  assign p_done   = (p_q[12:1] == '0);
  assign note_end = p_done && (code_q == rre_pkg::PauseCode);

  always_comb begin
    state_d      = state_q;
    bytes_left_d = bytes_left_q;
    vibra_time_d = vibra_time_q;
    vibra_on_d   = vibra_on_q;
    ovf_d        = ovf_q;
    note_d       = note_q;
    p_d          = p_q;
    code_d       = code_q;
    len_d        = len_q;
    rem_d        = rem_q;
    acc_d        = acc_q;
    tog_d        = tog_q;
    idx_d        = idx_q;
    tot_d        = tot_q;
    alu_req      = '{op: rre_pkg::AluSub, a: bytes_left_q, b: rre_pkg::PairBytes};
    out_push     = 1'b0;
    out_item     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          note_d = note_code_i;
          p_d    = dur_sat;
          rem_d  = note_code_i;
          acc_d  = newer_q ? rre_pkg::BaseNewer : rre_pkg::BaseOlder;
          idx_d  = '0;
          unique case (opcode_i)
            rre_pkg::OpStart: begin
              bytes_left_d = cap_q;
              vibra_time_d = '0;
              vibra_on_d   = 1'b1;
              ovf_d        = 1'b0;
              state_d      = StHdrChk;
            end
            rre_pkg::OpNote: begin
              state_d = ovf_q ? StFail : StVibChk;
            end
            rre_pkg::OpFinish: begin
              state_d = ovf_q ? StFail : StTrlChk;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StHdrChk: begin
        alu_req = '{op: rre_pkg::AluSub, a: bytes_left_q, b: rre_pkg::HdrBytes};
        if (alu_rsp.borrow) begin
          state_d = StFail;
        end else begin
          bytes_left_d = alu_rsp.res;
          state_d      = StHdrEmit;
        end
      end

      StHdrEmit: begin
        out_push      = 1'b1;
        out_item.data = rre_pkg::hdr_byte(idx_q);
        out_item.last = (idx_q == rre_pkg::HdrLast);
        if (out_ready) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == rre_pkg::HdrLast) begin
            state_d = StIdle;
          end
        end
      end

      StTrlChk: begin
        alu_req = '{op: rre_pkg::AluSub, a: bytes_left_q, b: rre_pkg::TrlBytes};
        if (alu_rsp.borrow) begin
          state_d = StFail;
        end else begin
          bytes_left_d = alu_rsp.res;
          state_d      = StTrlTot;
        end
      end

      StTrlTot: begin
        // Bytes used so far, rounded down to a multiple of four.
        alu_req = '{op: rre_pkg::AluSub, a: cap_q, b: bytes_left_q};
        tot_d   = {alu_rsp.res[15:2], 2'b00};
        state_d = StTrlEmit;
      end

      StTrlEmit: begin
        out_push       = 1'b1;
        out_item.data  = rre_pkg::trl_byte(idx_q);
        out_item.total = tot_q;
        out_item.last  = (idx_q == rre_pkg::TrlLast);
        if (out_ready) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == rre_pkg::TrlLast) begin
            state_d = StIdle;
          end
        end
      end

      StFail: begin
        out_push        = 1'b1;
        out_item.status = 1'b1;
        out_item.last   = 1'b1;
        if (out_ready) begin
          ovf_d   = 1'b1;
          state_d = StIdle;
        end
      end

      StVibChk: begin
        alu_req = '{op: rre_pkg::AluSub, a: vibra_time_q, b: rre_pkg::VibraLimit};
        tog_d   = !alu_rsp.borrow;
        state_d = StVibAdd;
      end

      StVibAdd: begin
        // A due toggle restarts the vibration count before this note is added.
        alu_req = '{op: rre_pkg::AluAdd, a: (tog_q ? '0 : vibra_time_q), b: {3'b000, p_q}};
        vibra_time_d = alu_rsp.res;
        state_d      = (note_q == rre_pkg::PauseNote) ? StPause : StDiv;
      end

      StPause: begin
        alu_req = '{op: rre_pkg::AluAdd, a: {3'b000, p_q}, b: 16'd1};
        p_d     = alu_rsp.res[12:0];
        code_d  = rre_pkg::PauseCode;
        state_d = tog_q ? StVibBud : StPairChk;
      end

      StDiv: begin
        // Octave search: take fourteen steps off and add twelve semitones.
        alu_req = '{op: rre_pkg::AluSub, a: {8'h00, rem_q}, b: {8'h00, rre_pkg::StepsPerOct}};
        if (alu_rsp.borrow) begin
          state_d = StCode;
        end else begin
          rem_d = alu_rsp.res[7:0];
          acc_d = acc_q + rre_pkg::SemisPerOct;
        end
      end

      StCode: begin
        alu_req = '{op: rre_pkg::AluAdd, a: {8'h00, acc_q},
                    b: {8'h00, rre_pkg::step_offset(rem_q[3:0])}};
        code_d  = alu_rsp.res[7:0];
        state_d = tog_q ? StVibBud : StPairChk;
      end

      StVibBud: begin
        if (alu_rsp.borrow) begin
          state_d = StFail;
        end else begin
          bytes_left_d = alu_rsp.res;
          state_d      = StVibE0;
        end
      end

      StVibE0: begin
        out_push      = 1'b1;
        out_item.data = rre_pkg::VibraMark;
        if (out_ready) begin
          state_d = StVibE1;
        end
      end

      StVibE1: begin
        out_push      = 1'b1;
        out_item.data = vibra_on_q ? rre_pkg::VibraOnByte : rre_pkg::VibraOffByte;
        out_item.last = note_end;
        if (out_ready) begin
          vibra_on_d = !vibra_on_q;
          state_d    = note_end ? StIdle : StPairChk;
        end
      end

      StPairChk: begin
        alu_req = '{op: rre_pkg::AluSub, a: {3'b000, p_q}, b: 16'd1};
        if (p_done) begin
          state_d = (code_q == rre_pkg::PauseCode) ? StIdle : StGapBud;
        end else begin
          len_d   = (p_q[12:8] != '0) ? rre_pkg::LengthMax : alu_rsp.res[7:0];
          state_d = StPairBud;
        end
      end

      StPairBud: begin
        if (alu_rsp.borrow) begin
          state_d = StFail;
        end else begin
          bytes_left_d = alu_rsp.res;
          state_d      = StPairE0;
        end
      end

      StPairE0: begin
        alu_req       = '{op: rre_pkg::AluSub, a: {3'b000, p_q}, b: {8'h00, len_q}};
        out_push      = 1'b1;
        out_item.data = code_q;
        if (out_ready) begin
          p_d     = alu_rsp.res[12:0];
          state_d = StPairE1;
        end
      end

      StPairE1: begin
        out_push      = 1'b1;
        out_item.data = len_q;
        out_item.last = note_end;
        if (out_ready) begin
          state_d = note_end ? StIdle : StPairChk;
        end
      end

      StGapBud: begin
        if (alu_rsp.borrow) begin
          state_d = StFail;
        end else begin
          bytes_left_d = alu_rsp.res;
          state_d      = StGapE0;
        end
      end

      StGapE0: begin
        out_push      = 1'b1;
        out_item.data = rre_pkg::PauseCode;
        if (out_ready) begin
          state_d = StGapE1;
        end
      end

      StGapE1: begin
        out_push      = 1'b1;
        out_item.data = rre_pkg::GapLength;
        out_item.last = 1'b1;
        if (out_ready) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cap_q        <= rre_pkg::CapacityReset;
      newer_q      <= 1'b0;
      bytes_left_q <= rre_pkg::CapacityReset;
      vibra_time_q <= '0;
      vibra_on_q   <= 1'b1;
      ovf_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      bytes_left_q <= bytes_left_d;
      vibra_time_q <= vibra_time_d;
      vibra_on_q   <= vibra_on_d;
      ovf_q        <= ovf_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rre_pkg::CfgCapacity: cap_q   <= cfg_data_i;
          rre_pkg::CfgFormat:   newer_q <= cfg_data_i[0];
          default:              cap_q   <= cap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
    p_q    <= p_d;
    code_q <= code_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    tog_q  <= tog_d;
    idx_q  <= idx_d;
    tot_q  <= tot_d;
  end

endmodule

### bench/tb.sv
// Self-checking testbench for the raw ringtone encoder core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no meaning to the encoder; it is accepted and dropped.
  localparam logic [1:0] OpIgnored = 2'd3;

  localparam int RandomItems   = 90;
  localparam int SettleCycles  = 200;  // longer than any item that yields no byte
  localparam int LongHold      = 300;  // one long receiver hold-off
  localparam int WatchdogLimit = 2000; // quiet cycles before the run is abandoned

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  note;
    logic [12:0] dur;
  } tone_item_t;

  // Clock, reset and every input of the block start at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = rre_pkg::CfgCapacity;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = rre_pkg::OpStart;
  logic [7:0]  note_code = '0;
  logic [12:0] duration = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_byte;
  logic        status;
  logic [15:0] total_length;
  logic        last_of_run;

  ringtone_raw_encoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .note_code_i     (note_code),
    .duration_units_i(duration),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .data_byte_o     (data_byte),
    .status_o        (status),
    .total_length_o  (total_length),
    .last_of_run_o   (last_of_run)
  );

  always #5 clk_i = ~clk_i;

  // Items waiting to be offered, and the bytes the encoder still owes us.
  tone_item_t         tone_items[$];
  rre_pkg::out_item_t expected_bytes[$];
  int                 items_queued = 0;
  int                 failures = 0;

  // Our own copy of the encoder's registers and running state.
  logic [15:0] capacity_cfg = rre_pkg::CapacityReset;
  logic        newer_cfg = 1'b0;
  logic [15:0] budget_left = rre_pkg::CapacityReset;
  logic [15:0] vibra_count = '0;
  logic        vibra_active = 1'b1;
  logic        buffer_full = 1'b0;
  int          run_len;

  // Fixed byte sequences of the stream and the semitone offset of each step.
  logic [7:0] header_seq [5] = '{8'h00, 8'h02, 8'hfc, 8'h0a, 8'h01};
  logic [7:0] trailer_seq [12] = '{8'h0a, 8'h0a, 8'h0a, 8'hfe, 8'h40, 8'h20,
                                   8'h07, 8'h0b, 8'hff, 8'hff, 8'hff, 8'hff};
  logic [7:0] step_semis [14] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd4, 8'd5,
                                  8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd11};

  // Handshake pacing: each side keeps its own count of cycles to wait.
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  // Set while the sender offers an item that has not been transferred yet.
  bit          sender_busy = 1'b0;

  // Every so often a side switches between random waits and a run of
  // back-to-back transfers, so that both dense and sparse traffic occur.
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [7:0] note,
                            input logic [12:0] dur);
    tone_item_t item;
    item.op = op;
    item.note = note;
    item.dur = dur;
    tone_items.push_back(item);
    if (op != OpIgnored) items_queued++;
  endtask

  task automatic put_byte(input logic [7:0] data, input logic flag, input logic [15:0] total);
    rre_pkg::out_item_t b;
    b.data = data;
    b.status = flag;
    b.total = total;
    b.last = 1'b0;
    expected_bytes.push_back(b);
    run_len++;
  endtask

  task automatic put_pair(input logic [7:0] first, input logic [7:0] second);
    put_byte(first, 1'b0, '0);
    put_byte(second, 1'b0, '0);
    budget_left = budget_left - rre_pkg::PairBytes;
  endtask

  // Works out the bytes one accepted item causes and appends them to the
  // store of expected bytes, updating our copy of the encoder state.
  task automatic encode_tone_item(input logic [1:0] op, input logic [7:0] note,
                                  input logic [12:0] dur);
    int                 p;
    int                 n;
    logic [7:0]         code;
    logic [7:0]         len;
    logic [15:0]        total;
    bit                 full;
    rre_pkg::out_item_t tail;
    full = 1'b0;
    run_len = 0;
    p = (dur > rre_pkg::MaxDuration) ? int'(rre_pkg::MaxDuration) : int'(dur);
    if (op == OpIgnored) return;

    if (op == rre_pkg::OpStart) begin
      budget_left = capacity_cfg;
      vibra_count = '0;
      vibra_active = 1'b1;
      buffer_full = 1'b0;
      if (budget_left < rre_pkg::HdrBytes) begin
        full = 1'b1;
      end else begin
        for (int i = 0; i < 5; i++) put_byte(header_seq[i], 1'b0, '0);
        budget_left = budget_left - rre_pkg::HdrBytes;
      end
    end else if (buffer_full) begin
      // Once the budget has run out, everything but a start just reports it.
      full = 1'b1;
    end else if (op == rre_pkg::OpFinish) begin
      if (budget_left < rre_pkg::TrlBytes) begin
        full = 1'b1;
      end else begin
        budget_left = budget_left - rre_pkg::TrlBytes;
        total = (capacity_cfg - budget_left) & 16'hfffc;
        for (int i = 0; i < 12; i++) put_byte(trailer_seq[i], 1'b0, total);
      end
    end else begin
      // A note: first the vibration toggle if enough time has built up.
      if (vibra_count >= rre_pkg::VibraLimit) begin
        if (budget_left < rre_pkg::PairBytes) begin
          full = 1'b1;
        end else begin
          put_pair(rre_pkg::VibraMark,
                   vibra_active ? rre_pkg::VibraOnByte : rre_pkg::VibraOffByte);
          vibra_count = '0;
          vibra_active = !vibra_active;
        end
      end
      if (!full) begin
        vibra_count = vibra_count + 16'(p);
        if (note == rre_pkg::PauseNote) begin
          code = rre_pkg::PauseCode;
          p++;
        end else begin
          n = int'(note);
          code = 8'(12 * (n / 14) + int'(step_semis[n % 14]) + (newer_cfg ? 90 : 114));
        end
        // The length is split into pairs of at most 255 units each.
        while (!full && p > 1) begin
          len = (p > 255) ? rre_pkg::LengthMax : 8'(p - 1);
          if (budget_left < rre_pkg::PairBytes) begin
            full = 1'b1;
          end else begin
            put_pair(code, len);
            p = p - int'(len);
          end
        end
        // A sounding note is followed by a short gap, unless its code happens
        // to coincide with the pause code.
        if (!full && code != rre_pkg::PauseCode) begin
          if (budget_left < rre_pkg::PairBytes) full = 1'b1;
          else put_pair(rre_pkg::PauseCode, rre_pkg::GapLength);
        end
      end
    end

    if (full) begin
      buffer_full = 1'b1;
      put_byte('0, 1'b1, '0);
    end
    if (run_len != 0) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endtask

  // Sender: offers queued items, predicting each one as its transfer
  // completes. A new item may follow in the same cycle, so valid is only
  // assigned once per edge.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    tone_item_t item;
    bit offering;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
      sender_busy = 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        encode_tone_item(opcode, note_code, duration);
        offering = 1'b0;
        gap_left = draw_wait(calm_in);
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (tone_items.size() != 0) begin
          item = tone_items.pop_front();
          opcode <= item.op;
          note_code <= item.note;
          duration <= item.dur;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
      sender_busy = offering;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Receiver: checks each result transfer against the oldest expected byte
  // and then draws its own stall before the next one. Once, on request, it
  // holds off for a long stretch so that the encoder backs up.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    rre_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          failures++;
          $display("%0t: result with nothing expected, expected none, got data %0h status %0b",
                   $time, data_byte, status);
        end else begin
          want = expected_bytes.pop_front();
          check_field("data_byte", want.data, data_byte);
          check_field("status", want.status, status);
          check_field("total_length", want.total, total_length);
          check_field("last_of_run", want.last, last_of_run);
        end
        stall_left = draw_wait(calm_out);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (hold_request && !hold_done) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  // Watchdog: gives up when neither channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Waits until every item has been taken and every byte has arrived, then
  // lets the encoder finish any item that produces no bytes at all.
  task automatic wait_idle();
    while (tone_items.size() != 0 || sender_busy || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes happen only while the encoder is idle; our copy of the
  // register is updated as soon as the write is driven.
  task automatic write_reg(input logic index, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    if (index == rre_pkg::CfgCapacity) capacity_cfg = value;
    else newer_cfg = value[0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int target;
    int phase;
    int notes;
    int sel;
    logic [12:0] dur;
    logic [7:0]  note;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset settings: a note before any start, the
    // ignored opcode, code extremes, a note whose code equals the pause code
    // (no gap follows it), empty pauses, long splits, saturation and a
    // repeated finish followed by a note outside a run.
    queue_item(rre_pkg::OpNote, 8'd30, 13'd40);
    queue_item(OpIgnored, 8'hff, 13'h1fff);
    queue_item(rre_pkg::OpStart, 8'd0, 13'd0);
    queue_item(rre_pkg::OpNote, 8'd0, 13'd2);
    queue_item(rre_pkg::OpNote, 8'd13, 13'h1fff);
    queue_item(rre_pkg::OpNote, 8'd14, 13'd1);
    queue_item(rre_pkg::OpNote, 8'd240, 13'd20);
    queue_item(rre_pkg::OpNote, 8'd254, 13'd0);
    queue_item(rre_pkg::OpNote, rre_pkg::PauseNote, 13'd0);
    queue_item(rre_pkg::OpNote, rre_pkg::PauseNote, 13'd1);
    queue_item(rre_pkg::OpNote, rre_pkg::PauseNote, 13'd256);
    queue_item(rre_pkg::OpNote, 8'd100, rre_pkg::MaxDuration);
    queue_item(rre_pkg::OpFinish, 8'd0, 13'd0);
    queue_item(rre_pkg::OpFinish, 8'd0, 13'd0);
    queue_item(rre_pkg::OpNote, 8'd20, 13'd3);
    wait_idle();

    // A small budget, newer format: the budget runs out in the middle of a
    // note, later items report the full buffer, and a start recovers.
    write_reg(rre_pkg::CfgFormat, {15'($urandom), 1'b1});
    write_reg(rre_pkg::CfgCapacity, 16'd40);
    queue_item(rre_pkg::OpStart, 8'd0, 13'd0);
    queue_item(rre_pkg::OpNote, 8'd0, 13'd600);
    queue_item(rre_pkg::OpNote, 8'd1, 13'd3000);
    queue_item(rre_pkg::OpNote, 8'd2, 13'd5);
    queue_item(rre_pkg::OpFinish, 8'd0, 13'd0);
    queue_item(rre_pkg::OpStart, 8'd0, 13'd0);
    queue_item(rre_pkg::OpFinish, 8'd0, 13'd0);
    wait_idle();

    // Header and trailer fit exactly; a second trailer does not.
    write_reg(rre_pkg::CfgCapacity, 16'd17);
    queue_item(rre_pkg::OpStart, 8'd0, 13'd0);
    queue_item(rre_pkg::OpFinish, 8'd0, 13'd0);
    queue_item(rre_pkg::OpFinish, 8'd0, 13'd0);
    wait_idle();

    // No budget at all: even the header does not fit.
    write_reg(rre_pkg::CfgCapacity, 16'd0);
    queue_item(rre_pkg::OpStart, 8'd0, 13'd0);
    queue_item(rre_pkg::OpNote, 8'd5, 13'd10);
    wait_idle();

    // Random part, in phases with their own settings. Most traffic is
    // well-formed tunes with random notes; the rest is noise.
    target = items_queued + RandomItems;
    phase = 0;
    while (items_queued < target) begin
      if (phase == 0) begin
        write_reg(rre_pkg::CfgCapacity, 16'hffff);
        write_reg(rre_pkg::CfgFormat, {15'($urandom), 1'b0});
      end else begin
        sel = $urandom_range(0, 5);
        if (sel == 0) write_reg(rre_pkg::CfgCapacity, 16'hffff);
        else if (sel == 1) write_reg(rre_pkg::CfgCapacity, 16'($urandom_range(0, 4)));
        else if (sel == 5) write_reg(rre_pkg::CfgCapacity, 16'($urandom));
        else write_reg(rre_pkg::CfgCapacity, 16'($urandom_range(5, 300)));
        if ($urandom_range(0, 1) == 1) write_reg(rre_pkg::CfgFormat, 16'($urandom));
      end

      sel = items_queued + 24;
      while (items_queued < sel) begin
        if ($urandom_range(0, 4) != 0) begin
          queue_item(rre_pkg::OpStart, 8'($urandom), 13'($urandom));
          notes = $urandom_range(0, 6);
          repeat (notes) begin
            note = ($urandom_range(0, 5) == 0) ? rre_pkg::PauseNote : 8'($urandom);
            case ($urandom_range(0, 19))
              0:       dur = 13'($urandom);
              1, 2, 3: dur = 13'($urandom_range(0, 2000));
              default: dur = 13'($urandom_range(0, 400));
            endcase
            queue_item(rre_pkg::OpNote, note, dur);
          end
          if ($urandom_range(0, 7) != 0) begin
            queue_item(rre_pkg::OpFinish, 8'($urandom), 13'($urandom));
          end
        end else begin
          queue_item(2'($urandom), 8'($urandom), 13'($urandom));
        end
      end

      // In the first phase the receiver holds off for a long time while the
      // sender keeps offering, so the encoder fills up and stalls its input.
      if (phase == 0) hold_request = 1'b1;
      wait_idle();
      phase++;
    end

    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### files.f
hdl/rre_pkg.sv
hdl/rre_alu.sv
hdl/rre_out_stage.sv
hdl/ringtone_raw_encoder_core.sv
bench/tb.sv
